// ----- hw/rtl/srmt_pkg.sv -----
package srmt_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned GENE_COUNT  = 64;
  localparam int unsigned MAX_RESULTS = 64;

  // derived widths
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic clear;   // write token back to the first cell
    logic append;  // cell holding the token takes the row
    logic load;    // capture compare result into hit flag
    logic shift;   // hit flags move one cell toward the head
  } srmt_ctrl_t;

endpackage

// ----- hw/rtl/srmt_cell.sv -----
module srmt_cell
  import srmt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srmt_ctrl_t            ctrl_i,
  input  logic [GENE_COUNT-1:0] row_i,
  input  logic                  first_i,
  input  logic                  tok_i,
  output logic                  tok_o,
  input  logic                  hit_i,
  output logic                  hit_o
);

  logic [GENE_COUNT-1:0] row_q;
  logic                  tok_q, tok_d;
  logic                  hit_q, hit_d;

  // write token walks one cell per append, returns to the head on clear
  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.clear) begin
      tok_d = first_i;
    end else if (ctrl_i.append) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= first_i;
    end else begin
      tok_q <= tok_d;
    end
  end

  // stored row, written once by the append that finds the token here
  always_ff @(posedge clk_i) begin
    if (ctrl_i.append && tok_q) begin
      row_q <= row_i;
    end
  end

  // hit flag: compare on load, then drain toward the head
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.load) begin
      hit_d = (row_q == row_i);
    end else if (ctrl_i.shift) begin
      hit_d = hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign tok_o = tok_q;
  assign hit_o = hit_q;

endmodule

// ----- hw/rtl/state_row_match_table.sv -----
// Multi-match lookup table of network states.
// Command channel: op_i and state_bits_i are taken at a rising edge with
// start high and busy low. Clear (OP_CLEAR) and append (OP_APPEND) give no
// result and keep busy low, so they can follow back to back.
// An append to a full table is dropped. A query (OP_QUERY) compares the key
// against every stored row in the accept cycle; busy then stays high while
// the hit flags drain out of the cell row, one row per cycle.
// Results: result_valid_o marks each result for exactly one cycle, in
// ascending row order, the final one with last_o set; a query with no hit
// gives one result with found_o low. A query holds busy until its final
// result, so the next item is taken only once busy falls with it. Each hit
// is held until the next hit is found and shows up in the cycle after that;
// the last shows up with busy falling.
// The receiver cannot stall; results are never held.
// Reset empties the table at once; stored rows keep no reset value.
module state_row_match_table
  import srmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [63:0] state_bits_i,
  output logic        result_valid_o,
  output logic [5:0]  match_index_o,
  output logic        found_o,
  output logic        last_o,
  output logic        table_full_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] row_count_q;
  logic [IDX_W-1:0] scan_q;
  logic [RES_W-1:0] cnt_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             pend_v_q;
  logic             result_valid_q;
  logic [5:0]       match_index_q;
  logic             found_q;
  logic             last_q;
  logic             table_full_q;

  srmt_ctrl_t            ctrl;
  logic                  accept;
  logic                  full;
  logic                  scan_end;
  logic                  res_limit;
  logic [GENE_COUNT-1:0] key;
  logic [TABLE_DEPTH-1:0] tok;
  logic [TABLE_DEPTH:0]   hit;

  // command decode
  assign accept      = start && !busy;
  assign full        = (row_count_q == CNT_W'(TABLE_DEPTH));
  assign key         = state_bits_i[GENE_COUNT-1:0];
  assign ctrl.clear  = accept && (op_i == OP_CLEAR);
  assign ctrl.append = accept && (op_i == OP_APPEND) && !full;
  assign ctrl.load   = accept && (op_i == OP_QUERY);
  assign ctrl.shift  = (state_q == ST_SCAN);

  // scan stop conditions
  assign scan_end  = (CNT_W'(scan_q) == row_count_q - CNT_W'(1));
  assign res_limit = hit[0] && (cnt_q == RES_W'(MAX_RESULTS - 1));

  // row of cells, head at index 0
  assign hit[TABLE_DEPTH] = 1'b0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic tok_prev;
    if (k == 0) begin : g_head
      assign tok_prev = 1'b0;
    end else begin : g_body
      assign tok_prev = tok[k-1];
    end

    srmt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .row_i   (key),
      .first_i ((k == 0) ? 1'b1 : 1'b0),
      .tok_i   (tok_prev),
      .tok_o   (tok[k]),
      .hit_i   (hit[k+1]),
      .hit_o   (hit[k])
    );
  end

  // sequencer, row count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_count_q    <= '0;
      scan_q         <= '0;
      cnt_q          <= '0;
      pend_idx_q     <= '0;
      pend_v_q       <= 1'b0;
      result_valid_q <= 1'b0;
      match_index_q  <= '0;
      found_q        <= 1'b0;
      last_q         <= 1'b0;
      table_full_q   <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl.clear) begin
            row_count_q <= '0;
          end
          if (ctrl.append) begin
            row_count_q <= row_count_q + CNT_W'(1);
          end
          if (ctrl.load) begin
            scan_q   <= '0;
            cnt_q    <= '0;
            pend_v_q <= 1'b0;
            state_q  <= (row_count_q == '0) ? ST_FLUSH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // a new hit releases the one held before it
          if (hit[0]) begin
            if (pend_v_q) begin
              result_valid_q <= 1'b1;
              match_index_q  <= 6'(pend_idx_q);
              found_q        <= 1'b1;
              last_q         <= 1'b0;
              table_full_q   <= full;
            end
            pend_idx_q <= scan_q;
            pend_v_q   <= 1'b1;
            cnt_q      <= cnt_q + RES_W'(1);
          end
          if (scan_end || res_limit) begin
            state_q <= ST_FLUSH;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          // final hit, or the no-match result
          result_valid_q <= 1'b1;
          match_index_q  <= pend_v_q ? 6'(pend_idx_q) : 6'd0;
          found_q        <= pend_v_q;
          last_q         <= 1'b1;
          table_full_q   <= full;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign match_index_o  = match_index_q;
  assign found_o        = found_q;
  assign last_o         = last_q;
  assign table_full_o   = table_full_q;

endmodule

// ----- hw/rtl/srmt_checker.sv -----
module srmt_checker
  import srmt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op_i,
  input logic        result_valid_o,
  input logic [5:0]  match_index_o,
  input logic        found_o,
  input logic        last_o,
  input logic        table_full_o
);

  // a miss is always a run of one
  a_miss_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !found_o |-> last_o && (match_index_o == 6'd0))
    else $error("no-match result not marked last");

  // a query transfer opens a busy window
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (op_i == OP_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // busy ends exactly with the final result of the run
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && last_o)
    else $error("busy fell without a final result");

  // results before the final one arrive while the run is still open
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("intermediate result outside a query run");

  // full flag holds within a run
  a_full_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> !result_valid_o || $stable(table_full_o))
    else $error("table_full changed within a run");

endmodule

bind state_row_match_table srmt_checker u_srmt_checker (.*);

// ----- tb/tb_state_row_match_table.sv -----
module tb_state_row_match_table;
  import srmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op value the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [63:0] GENE_MASK =
    (GENE_COUNT >= 64) ? '1 : ((64'd1 << GENE_COUNT) - 64'd1);
  localparam logic [63:0] ONES = '1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DIR_ROWS = 24;
  localparam int unsigned PHASES = 3;
  localparam int unsigned PHASE_ITEMS = 40;

  // one lookup result as it leaves the block
  typedef struct packed {
    logic [5:0] index;
    logic       found;
    logic       last;
    logic       full;
  } hit_t;

  // directed command with an optional hand-written expected hit
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] bits;
    logic        typed;
    hit_t        want;
  } dir_cmd_t;

  localparam hit_t MISS_NOT_FULL = '{index: 6'd0, found: 1'b0, last: 1'b1, full: 1'b0};
  localparam hit_t NONE          = '0;

  localparam dir_cmd_t DIR_TBL [DIR_ROWS] = '{
    '{OP_QUERY,  64'h0,                  1'b1, MISS_NOT_FULL},
    '{OP_QUERY,  ONES,                   1'b1, MISS_NOT_FULL},
    '{OP_UNUSED, ONES,                   1'b0, NONE},
    '{OP_APPEND, 64'h0,                  1'b0, NONE},
    '{OP_APPEND, ONES,                   1'b0, NONE},
    '{OP_APPEND, 64'h0,                  1'b0, NONE},
    '{OP_APPEND, 64'h8000_0000_0000_0001, 1'b0, NONE},
    '{OP_QUERY,  64'h0,                  1'b0, NONE},
    '{OP_QUERY,  ONES,                   1'b1, '{6'd1, 1'b1, 1'b1, 1'b0}},
    '{OP_QUERY,  64'h8000_0000_0000_0001, 1'b1, '{6'd3, 1'b1, 1'b1, 1'b0}},
    '{OP_QUERY,  64'h0000_0000_0000_0001, 1'b1, MISS_NOT_FULL},
    '{OP_QUERY,  64'h8000_0000_0000_0000, 1'b1, MISS_NOT_FULL},
    '{OP_UNUSED, 64'h0,                  1'b0, NONE},
    '{OP_QUERY,  64'h0,                  1'b0, NONE},
    '{OP_APPEND, 64'h5555_5555_5555_5555, 1'b0, NONE},
    '{OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NONE},
    '{OP_QUERY,  64'h5555_5555_5555_5555, 1'b1, '{6'd4, 1'b1, 1'b1, 1'b0}},
    '{OP_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{6'd5, 1'b1, 1'b1, 1'b0}},
    '{OP_CLEAR,  64'h0,                  1'b0, NONE},
    '{OP_QUERY,  64'h0,                  1'b1, MISS_NOT_FULL},
    '{OP_CLEAR,  ONES,                   1'b0, NONE},
    '{OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NONE},
    '{OP_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{6'd0, 1'b1, 1'b1, 1'b0}},
    '{OP_CLEAR,  64'h0,                  1'b0, NONE}
  };

  localparam int unsigned PHASE_IDLE [PHASES] = '{0, 48, 38};

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = OP_CLEAR;
  logic [63:0] state_bits_i = '0;
  logic        result_valid_o;
  logic [5:0]  match_index_o;
  logic        found_o;
  logic        last_o;
  logic        table_full_o;

  // shadow copy of the stored rows
  logic [63:0] ref_rows [TABLE_DEPTH];
  int unsigned ref_count = 0;

  hit_t        expected_hits [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_items = 0;
  int unsigned idle_pct = 0;

  state_row_match_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .state_bits_i   (state_bits_i),
    .result_valid_o (result_valid_o),
    .match_index_o  (match_index_o),
    .found_o        (found_o),
    .last_o         (last_o),
    .table_full_o   (table_full_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // update the shadow table and queue the hits a command causes
  function automatic void apply_table_cmd(input logic [1:0] op, input logic [63:0] key);
    logic [63:0] k;
    hit_t        h;
    logic        full;
    int          total;
    int          n;
    k = key & GENE_MASK;
    case (op)
      OP_CLEAR: ref_count = 0;
      OP_APPEND: begin
        // rows past the end are dropped
        if (ref_count < TABLE_DEPTH) begin
          ref_rows[ref_count] = k;
          ref_count++;
        end
      end
      OP_QUERY: begin
        full = (ref_count >= TABLE_DEPTH);
        total = 0;
        for (int r = 0; r < int'(ref_count); r++) begin
          if (ref_rows[r] == k && total < int'(MAX_RESULTS)) total++;
        end
        n = 0;
        for (int r = 0; r < int'(ref_count); r++) begin
          if (ref_rows[r] == k && n < total) begin
            h = '0;
            h.index = 6'(r);
            h.found = 1'b1;
            h.last = (n == total - 1);
            h.full = full;
            expected_hits.push_back(h);
            n++;
          end
        end
        // a miss still gives one result
        if (total == 0) begin
          h = '0;
          h.last = 1'b1;
          h.full = full;
          expected_hits.push_back(h);
        end
      end
      default: ;
    endcase
  endfunction

  // one command transfer, with random idle cycles ahead of it
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] bits,
                          input logic typed, input hit_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    state_bits_i <= bits;
    do @(posedge clk_i); while (busy);
    if (typed) expected_hits.push_back(want);
    else apply_table_cmd(op, bits);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // random extreme or random word
  function automatic logic [63:0] rand_state();
    logic [63:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = ONES;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // fill the table from a small pool of states, then look them up
  task automatic run_episode(input int rows, input int queries, input int pool_n,
                             input logic may_keep);
    logic [63:0] pool [4];
    logic [63:0] key;
    for (int i = 0; i < 4; i++) pool[i] = rand_state();
    if (!may_keep || $urandom_range(4) != 0) send_cmd(OP_CLEAR, rand_state(), 1'b0, NONE);
    for (int i = 0; i < rows; i++) begin
      if ($urandom_range(7) == 0) key = {$urandom, $urandom};
      else key = pool[$urandom_range(pool_n - 1)];
      send_cmd(OP_APPEND, key, 1'b0, NONE);
      // lookups while the table is still filling
      if ($urandom_range(3) == 0)
        send_cmd(OP_QUERY, pool[$urandom_range(pool_n - 1)], 1'b0, NONE);
    end
    for (int i = 0; i < queries; i++) begin
      case ($urandom_range(19))
        0, 1, 2: key = pool[$urandom_range(pool_n - 1)] ^ (64'd1 << $urandom_range(63));
        3, 4: key = {$urandom, $urandom};
        default: key = pool[$urandom_range(pool_n - 1)];
      endcase
      if ($urandom_range(15) == 0) send_cmd(OP_UNUSED, {$urandom, $urandom}, 1'b0, NONE);
      send_cmd(OP_QUERY, key, 1'b0, NONE);
    end
  endtask

  // stimulus
  initial begin
    int unsigned mark;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands
    for (int i = 0; i < int'(DIR_ROWS); i++)
      send_cmd(DIR_TBL[i].op, DIR_TBL[i].bits, DIR_TBL[i].typed, DIR_TBL[i].want);

    // random episodes under each idle setting
    for (int p = 0; p < int'(PHASES); p++) begin
      idle_pct = PHASE_IDLE[p];
      mark = sent_items;
      // overfill the table so a lookup runs the full result length
      if (p > 0) run_episode(int'(TABLE_DEPTH) + 2 + p, 4, p, 1'b0);
      while (sent_items - mark < PHASE_ITEMS)
        run_episode($urandom_range(1, 10), $urandom_range(2, 6), $urandom_range(1, 4), 1'b1);
    end

    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
    if (err_cnt == 0 && expected_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result check against the oldest expected hit
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_hits.size() == 0) begin
        err_cnt++;
        if (err_cnt < 50)
          $display("%0t unexpected result: idx=%0d found=%0b last=%0b full=%0b",
                   $time, match_index_o, found_o, last_o, table_full_o);
      end else begin
        want = expected_hits.pop_front();
        if (match_index_o !== want.index || found_o !== want.found ||
            last_o !== want.last || table_full_o !== want.full) begin
          err_cnt++;
          if (err_cnt < 50)
            $display({"%0t mismatch: expected idx=%0d found=%0b last=%0b full=%0b,",
                      " got idx=%0d found=%0b last=%0b full=%0b"},
                     $time, want.index, want.found, want.last, want.full,
                     match_index_o, found_o, last_o, table_full_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/srmt_pkg.sv
hw/rtl/srmt_cell.sv
hw/rtl/state_row_match_table.sv
hw/rtl/srmt_checker.sv
tb/tb_state_row_match_table.sv
